/* rtl/assert_macros.svh */
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked at every rising clock edge outside reset.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* rtl/s3e_pkg.sv */
// Package with constants, CORDIC table and helpers for the 3x3 eigenvector block.
`default_nettype none
package s3e_pkg;
  localparam int SweepsDef   = 16;
  localparam int CordicSteps = 30;
  localparam int StepW       = 5;
  localparam logic [1:0] RegStopThreshold = 2'd0;
  localparam logic signed [63:0] KinvQ30 = 64'sd652032874;
  localparam logic signed [63:0] OneQ30  = 64'sd1073741824;
  localparam logic signed [63:0] AngPi   = 64'sd2147483648;

  function automatic logic signed [63:0] atan_tab(input logic [StepW-1:0] i);
    logic signed [63:0] t;
    begin
      case (i)
        5'd0: t = 64'sd536870912;
        5'd1: t = 64'sd316933406;
        5'd2: t = 64'sd167458907;
        5'd3: t = 64'sd85004756;
        5'd4: t = 64'sd42667331;
        5'd5: t = 64'sd21354465;
        5'd6: t = 64'sd10679838;
        5'd7: t = 64'sd5340245;
        5'd8: t = 64'sd2670163;
        5'd9: t = 64'sd1335087;
        5'd10: t = 64'sd667544;
        5'd11: t = 64'sd333772;
        5'd12: t = 64'sd166886;
        5'd13: t = 64'sd83443;
        5'd14: t = 64'sd41722;
        5'd15: t = 64'sd20861;
        5'd16: t = 64'sd10430;
        5'd17: t = 64'sd5215;
        5'd18: t = 64'sd2608;
        5'd19: t = 64'sd1304;
        5'd20: t = 64'sd652;
        5'd21: t = 64'sd326;
        5'd22: t = 64'sd163;
        5'd23: t = 64'sd81;
        5'd24: t = 64'sd41;
        5'd25: t = 64'sd20;
        5'd26: t = 64'sd10;
        5'd27: t = 64'sd5;
        5'd28: t = 64'sd3;
        5'd29: t = 64'sd1;
        default: t = 64'sd0;
      endcase
      return t;
    end
  endfunction

  function automatic logic signed [63:0] clamp64(input logic signed [63:0] v,
                                                 input logic signed [63:0] lim);
    begin
      if (v > lim) return lim;
      else if (v < -lim) return -lim;
      else return v;
    end
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    begin
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      else if (v < -64'sd2147483648) return 32'sh80000000;
      else return v[31:0];
    end
  endfunction
endpackage
`default_nettype wire

/* rtl/symmetric_3x3_smallest_eigenvector.sv */
// Top level: Jacobi 3x3 smallest eigenvector with a shared CORDIC and MAC unit.
// Channel  | Ports                                  | Handshake
// in       | in_cov_xx..in_cov_zz                   | start/busy
// out      | out_vec_x, out_vec_y, out_vec_z        | out_valid strobe
// cfg      | psel penable pwrite paddr pwdata prdata| APB, pready high
// One item takes up to SWEEPS rotations, each made of 1 pivot search,
// 30 vectoring steps, 1 phase load, 30 rotation steps and 15 steps on one
// multiplier pair, then 1 final pivot search and 1 output load before the
// result strobe.
// Reset clears the sequencer and sets stop_threshold to 1.
// The receiver cannot stall; out_valid pulses for one cycle, busy is low then.
`default_nettype none
module symmetric_3x3_smallest_eigenvector #(
  parameter int SWEEPS = s3e_pkg::SweepsDef
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         start,
  output logic        busy,
  input  wire  signed [31:0] in_cov_xx,
  input  wire  signed [31:0] in_cov_xy,
  input  wire  signed [31:0] in_cov_xz,
  input  wire  signed [31:0] in_cov_yy,
  input  wire  signed [31:0] in_cov_yz,
  input  wire  signed [31:0] in_cov_zz,
  output logic        out_valid,
  output logic signed [15:0] out_vec_x,
  output logic signed [15:0] out_vec_y,
  output logic signed [15:0] out_vec_z,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [1:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import s3e_pkg::*;
`include "assert_macros.svh"

  localparam int ItW = $clog2(SWEEPS + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PIV   = 3'd1;
  localparam logic [2:0] S_VEC   = 3'd2;
  localparam logic [2:0] S_ROT   = 3'd3;
  localparam logic [2:0] S_MAC   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;
  localparam logic [2:0] S_HALF  = 3'd6;

  logic [2:0] st_r, st_nxt;
  logic [15:0] thr_r;
  logic [ItW-1:0] it_r;
  logic [StepW-1:0] k_r;
  logic [3:0] mstep_r;
  logic [1:0] p_r, q_r, r_r;
  logic signed [31:0] a_r [6];   // 00 01 02 11 12 22
  logic signed [31:0] v_r [9];   // row*3+col, Q2.30
  logic signed [63:0] cx_r, cy_r, cz_r;
  logic signed [31:0] c_r, s_r, cc_r, ss_r, sc2_r;
  logic signed [63:0] t0_r, t1_r;

  assign pready = 1'b1;
  assign prdata = (paddr == RegStopThreshold) ? {16'd0, thr_r} : 32'd0;
  assign busy = (st_r != S_IDLE);

  function automatic logic [2:0] aidx(input logic [1:0] i, input logic [1:0] j);
    logic [1:0] lo, hi;
    begin
      lo = (i < j) ? i : j;
      hi = (i < j) ? j : i;
      if (lo == 2'd0) return {1'b0, hi};
      else if (lo == 2'd1) return {1'b0, hi} + 3'd2;
      else return 3'd5;
    end
  endfunction

  // pivot search
  logic signed [63:0] m01, m02, m12, mag;
  logic [1:0] pp_sel, qq_sel, rr_sel;
  always_comb begin
    m01 = a_r[1] < 0 ? -64'(a_r[1]) : 64'(a_r[1]);
    m02 = a_r[2] < 0 ? -64'(a_r[2]) : 64'(a_r[2]);
    m12 = a_r[4] < 0 ? -64'(a_r[4]) : 64'(a_r[4]);
    pp_sel = 2'd0; qq_sel = 2'd1; rr_sel = 2'd2; mag = m01;
    if (m02 > mag) begin pp_sel = 2'd0; qq_sel = 2'd2; rr_sel = 2'd1; mag = m02; end
    if (m12 > mag) begin pp_sel = 2'd1; qq_sel = 2'd2; rr_sel = 2'd0; mag = m12; end
  end

  // shared CORDIC step
  logic signed [63:0] shx, shy, ang;
  always_comb begin
    shx = cx_r >>> k_r;
    shy = cy_r >>> k_r;
    ang = atan_tab(k_r);
  end

  // shared multiplier pair: operands chosen by mac step
  logic signed [31:0] ma, mb, mc, md, app, aqq, apq, arp, arq, vp, vq;
  logic signed [63:0] prod0, prod1, psum, rsum, accin, racc;
  logic signed [63:0] r0, r1, c_lim, s_lim, sc2_lim, v_lim;
  logic [1:0] vrow;
  logic [3:0] vip, viq;
  always_comb begin
    app = a_r[aidx(p_r, p_r)];
    aqq = a_r[aidx(q_r, q_r)];
    apq = a_r[aidx(p_r, q_r)];
    arp = a_r[aidx(r_r, p_r)];
    arq = a_r[aidx(r_r, q_r)];
    case (mstep_r)
      4'd9, 4'd10: vrow = 2'd0;
      4'd11, 4'd12: vrow = 2'd1;
      4'd13, 4'd14: vrow = 2'd2;
      default: vrow = 2'd0;
    endcase
    vip = {2'b00, vrow} * 4'd3 + {2'b00, p_r};
    viq = {2'b00, vrow} * 4'd3 + {2'b00, q_r};
    vp = v_r[vip];
    vq = v_r[viq];
    ma = 32'sd0; mb = 32'sd0; mc = 32'sd0; md = 32'sd0;
    case (mstep_r)
      4'd1: begin ma = c_r; mb = c_r; mc = s_r; md = s_r; end
      4'd2: begin ma = s_r; mb = c_r; end
      4'd3: begin ma = c_r; mb = arp; mc = -s_r; md = arq; end
      4'd4: begin ma = s_r; mb = arp; mc = c_r; md = arq; end
      4'd5: begin ma = cc_r; mb = app; mc = -sc2_r; md = apq; end
      4'd6: begin ma = ss_r; mb = aqq; end
      4'd7: begin ma = ss_r; mb = app; mc = sc2_r; md = apq; end
      4'd8: begin ma = cc_r; mb = aqq; end
      4'd9, 4'd11, 4'd13: begin ma = c_r; mb = vp; mc = -s_r; md = vq; end
      4'd10, 4'd12, 4'd14: begin ma = s_r; mb = vp; mc = c_r; md = vq; end
      default: ;
    endcase
    prod0 = 64'(ma) * 64'(mb);
    prod1 = 64'(mc) * 64'(md);
    psum = prod0 + prod1;
    rsum = (psum + 64'sd536870912) >>> 30;
    r0 = (prod0 + 64'sd536870912) >>> 30;
    r1 = (prod1 + 64'sd536870912) >>> 30;
    // diagonal updates round the full three-term sum once
    accin = (mstep_r == 4'd6) ? t0_r : t1_r;
    racc = (accin + prod0 + 64'sd536870912) >>> 30;
    sc2_lim = clamp64((2 * prod0 + 64'sd536870912) >>> 30, OneQ30);
    v_lim = clamp64(rsum, OneQ30);
    c_lim = clamp64(cx_r, OneQ30);
    s_lim = clamp64(cy_r, OneQ30);
  end

  // output selection
  logic [1:0] best;
  logic signed [63:0] o0, o1, o2;
  always_comb begin
    best = 2'd0;
    if (a_r[3] < a_r[0]) best = 2'd1;
    if (a_r[5] < ((best == 2'd1) ? a_r[3] : a_r[0])) best = 2'd2;
    o0 = clamp64((64'(v_r[0 + best]) + 64'sd32768) >>> 16, 64'sd16384);
    o1 = clamp64((64'(v_r[3 + best]) + 64'sd32768) >>> 16, 64'sd16384);
    o2 = clamp64((64'(v_r[6 + best]) + 64'sd32768) >>> 16, 64'sd16384);
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: if (start) st_nxt = S_PIV;
      S_PIV: begin
        if (it_r == ItW'(SWEEPS) || mag == 64'sd0 || mag < 64'(thr_r)) st_nxt = S_OUT;
        else st_nxt = S_VEC;
      end
      S_VEC: if (k_r == StepW'(CordicSteps - 1)) st_nxt = S_HALF;
      S_HALF: st_nxt = S_ROT;
      S_ROT: if (k_r == StepW'(CordicSteps - 1)) st_nxt = S_MAC;
      S_MAC: if (mstep_r == 4'd14) st_nxt = S_PIV;
      S_OUT: st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      thr_r <= 16'd1;
      out_valid <= 1'b0;
      it_r <= '0;
      k_r <= '0;
      mstep_r <= '0;
    end else begin
      st_r <= st_nxt;
      out_valid <= (st_r == S_OUT);
      if (psel && penable && pwrite && paddr == RegStopThreshold) thr_r <= pwdata[15:0];
      case (st_r)
        S_IDLE: if (start) begin
          a_r[0] <= in_cov_xx; a_r[1] <= in_cov_xy; a_r[2] <= in_cov_xz;
          a_r[3] <= in_cov_yy; a_r[4] <= in_cov_yz; a_r[5] <= in_cov_zz;
          for (int i = 0; i < 9; i++)
            v_r[i] <= (i == 0 || i == 4 || i == 8) ? 32'sh40000000 : 32'sd0;
          it_r <= '0;
        end
        S_PIV: begin
          p_r <= pp_sel; q_r <= qq_sel; r_r <= rr_sel;
          k_r <= '0;
          // x = aqq-app, y = 2*apq; pre-turn by pi when x is negative
          cx_r <= 64'(a_r[aidx(qq_sel, qq_sel)]) - 64'(a_r[aidx(pp_sel, pp_sel)]);
          cy_r <= 2 * 64'(a_r[aidx(pp_sel, qq_sel)]);
          cz_r <= 64'sd0;
          if (64'(a_r[aidx(qq_sel, qq_sel)]) < 64'(a_r[aidx(pp_sel, pp_sel)])) begin
            cx_r <= 64'(a_r[aidx(pp_sel, pp_sel)]) - 64'(a_r[aidx(qq_sel, qq_sel)]);
            cy_r <= -2 * 64'(a_r[aidx(pp_sel, qq_sel)]);
            cz_r <= (a_r[aidx(pp_sel, qq_sel)] >= 0) ? AngPi : -AngPi;
          end
        end
        S_VEC: begin
          if (cy_r > 0) begin
            cx_r <= cx_r + shy; cy_r <= cy_r - shx; cz_r <= cz_r + ang;
          end else begin
            cx_r <= cx_r - shy; cy_r <= cy_r + shx; cz_r <= cz_r - ang;
          end
          k_r <= k_r + 1'b1;
          if (k_r == StepW'(CordicSteps - 1)) begin
            k_r <= '0;
          end
        end
        S_HALF: begin
          // load rotation start from halved phase
          cz_r <= cz_r >>> 1;
          cx_r <= KinvQ30; cy_r <= 64'sd0;
        end
        S_ROT: begin
          if (cz_r >= 0) begin
            cx_r <= cx_r - shy; cy_r <= cy_r + shx; cz_r <= cz_r - ang;
          end else begin
            cx_r <= cx_r + shy; cy_r <= cy_r - shx; cz_r <= cz_r + ang;
          end
          k_r <= k_r + 1'b1;
          mstep_r <= '0;
        end
        S_MAC: begin
          mstep_r <= mstep_r + 1'b1;
          case (mstep_r)
            4'd0: begin c_r <= c_lim[31:0]; s_r <= s_lim[31:0]; end
            4'd1: begin cc_r <= r0[31:0]; ss_r <= r1[31:0]; end
            4'd2: sc2_r <= sc2_lim[31:0];
            4'd3: t0_r <= 64'(sat32(rsum));
            4'd4: begin
              t1_r <= 64'(sat32(rsum));
              a_r[aidx(r_r, p_r)] <= t0_r[31:0];
            end
            4'd5: begin
              a_r[aidx(r_r, q_r)] <= t1_r[31:0];
              t0_r <= psum;
            end
            4'd6: t0_r <= 64'(sat32(racc));
            4'd7: t1_r <= psum;
            4'd8: begin
              t1_r <= 64'(sat32(racc));
              a_r[aidx(p_r, p_r)] <= t0_r[31:0];
            end
            4'd9, 4'd11, 4'd13: begin
              if (mstep_r == 4'd9) begin
                a_r[aidx(q_r, q_r)] <= t1_r[31:0];
                a_r[aidx(p_r, q_r)] <= 32'sd0;
              end
              // hold the p column value until the q column is computed
              t0_r <= v_lim;
            end
            4'd10, 4'd12, 4'd14: begin
              v_r[vip] <= t0_r[31:0];
              v_r[viq] <= v_lim[31:0];
            end
            default: ;
          endcase
          if (mstep_r == 4'd14) it_r <= it_r + 1'b1;
        end
        S_OUT: begin
          out_vec_x <= o0[15:0]; out_vec_y <= o1[15:0]; out_vec_z <= o2[15:0];
        end
        default: ;
      endcase
    end
  end

  `ASSERT_NXT(a_out_pulse, clk, rst_n, out_valid, !out_valid)
  `ASSERT_IMP(a_busy_out, clk, rst_n, out_valid, !busy)
  `ASSERT_IMP(a_it_bound, clk, rst_n, busy, it_r <= ItW'(SWEEPS))
endmodule
`default_nettype wire
